// File: rtl/core/cla_pkg.sv
// Package for the command line assembler: transaction structs, opcode, event,
// termination mode and state encodings, and the control byte constants.
// No dependencies.
package cla_pkg;

  // Default size of the line store in bytes.
  localparam int unsigned CLA_LINE_BYTES = 4096;

  // Fixed field widths of the transactions.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned LENGTH_W = 12;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_READ  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    EV_ECHO      = 4'd0,
    EV_ERASED    = 4'd1,
    EV_ERASE_IGN = 4'd2,
    EV_OVERFLOW  = 4'd3,
    EV_SENT      = 4'd4,
    EV_BLANK     = 4'd5,
    EV_EXITED    = 4'd6,
    EV_STARTED   = 4'd7,
    EV_BUSY      = 4'd8,
    EV_READ      = 4'd9,
    EV_IGNORE    = 4'd10
  } event_t;

  typedef enum logic [1:0] {
    TM_NUL  = 2'd0,
    TM_CR   = 2'd1,
    TM_LF   = 2'd2,
    TM_CRLF = 2'd3
  } eol_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Control characters of the terminal stream.
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_DC1   = 8'h11;
  localparam logic [BYTE_W-1:0] CH_CAN   = 8'h18;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    opcode_t              opcode;
    logic [BYTE_W-1:0]    data_byte;
    logic [INDEX_W-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    event_t               event_res;
    logic [BYTE_W-1:0]    out_byte;
    logic [LENGTH_W-1:0]  length_now;
    logic                 quoted;
  } out_item_t;

endpackage

// File: rtl/core/cla_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Width and depth are parameters; no package dependency.
module cla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read that lands in rdata next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/core/cla_ctrl.sv
// Sequencer of the command line assembler: session, length and quote state,
// line store accesses, blank line scan and the output register.
// Depends on cla_pkg; drives the port of one cla_ram instance.
module cla_ctrl #(
  parameter int unsigned LINE_BYTES = cla_pkg::CLA_LINE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cla_pkg::eol_mode_t            eol_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cla_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cla_pkg::out_item_t            out_data,
  output logic                          ram_en,
  output logic                          ram_we,
  output logic [$clog2(LINE_BYTES)-1:0] ram_addr,
  output logic [7:0]                    ram_wdata,
  input  logic [7:0]                    ram_rdata
);
  import cla_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BYTES);

  state_t          state, state_next;
  in_item_t        item, item_next;
  logic [AW-1:0]   len, len_next;
  logic            quotes, quotes_next;
  logic            active, active_next;
  logic [7:0]      prev, prev_next;
  logic [AW-1:0]   scan_idx, scan_idx_next;
  logic            scan_pend, scan_pend_next;
  logic [AW-1:0]   send_len, send_len_next;
  out_item_t       res;
  logic            emit;
  logic            can_emit;
  logic            hold;
  logic            mem_en;
  logic            mem_we;
  logic            is_erase;
  logic            is_send;
  logic            is_full;
  logic            in_range;

  assign can_emit = !out_valid || out_ready;
  assign hold     = emit && !can_emit;
  assign ram_en   = mem_en && !hold;
  assign ram_we   = mem_we && !hold;

  // Decode of the byte held in the item register.
  assign is_erase = (item.data_byte == CH_BS) || (item.data_byte == CH_DEL);
  assign is_full  = len >= AW'(LINE_BYTES - 1);
  assign in_range = 32'(item.read_index) < LINE_BYTES;
  assign is_send  = !quotes &&
                    (((item.data_byte == CH_NUL) && (eol_mode == TM_NUL)) ||
                     ((item.data_byte == CH_CR) && (eol_mode == TM_CR)) ||
                     ((item.data_byte == CH_LF) &&
                      ((eol_mode == TM_LF) ||
                       ((eol_mode == TM_CRLF) && (len != '0) &&
                        (ram_rdata == CH_CR)))));

  // Next state, line store port and result of the current step.
  always_comb begin
    state_next     = state;
    item_next      = item;
    len_next       = len;
    quotes_next    = quotes;
    active_next    = active;
    prev_next      = prev;
    scan_idx_next  = scan_idx;
    scan_pend_next = scan_pend;
    send_len_next  = send_len;
    in_ready       = 1'b0;
    emit           = 1'b0;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    ram_addr       = len - 1'b1;
    ram_wdata      = item.data_byte;
    res            = '{EV_IGNORE, 8'h00, LENGTH_W'(len), quotes};

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Read the last stored byte, or the requested byte for a read.
          item_next  = in_data;
          mem_en     = 1'b1;
          ram_addr   = (in_data.opcode == OP_READ) ? AW'(in_data.read_index) : len - 1'b1;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (item.opcode)
          OP_START: begin
            emit       = 1'b1;
            state_next = ST_IDLE;
            if (active) begin
              res.event_res = EV_BUSY;
            end else begin
              active_next   = 1'b1;
              res.event_res = EV_STARTED;
            end
          end

          OP_BYTE: begin
            if (!active) begin
              emit       = 1'b1;
              state_next = ST_IDLE;
            end else if ((prev == CH_CAN) && (item.data_byte == CH_DC1)) begin
              // Exit pair closes the session and clears the line.
              emit        = 1'b1;
              state_next  = ST_IDLE;
              active_next = 1'b0;
              quotes_next = 1'b0;
              prev_next   = CH_NUL;
              len_next    = '0;
              res         = '{EV_EXITED, 8'h00, '0, 1'b0};
            end else begin
              prev_next = item.data_byte;
              if (is_erase) begin
                emit       = 1'b1;
                state_next = ST_IDLE;
                if (len != '0) begin
                  len_next       = len - 1'b1;
                  res.event_res  = EV_ERASED;
                  res.length_now = LENGTH_W'(len - 1'b1);
                end else begin
                  res.event_res = EV_ERASE_IGN;
                end
              end else if (is_send) begin
                // Terminator: clear the line and scan it for content.
                len_next       = '0;
                quotes_next    = 1'b0;
                send_len_next  = len;
                scan_idx_next  = '0;
                scan_pend_next = 1'b0;
                state_next     = ST_SCAN;
              end else if (is_full) begin
                emit          = 1'b1;
                state_next    = ST_IDLE;
                res.event_res = EV_OVERFLOW;
              end else begin
                // Store and echo the byte.
                emit        = 1'b1;
                state_next  = ST_IDLE;
                mem_en      = 1'b1;
                mem_we      = 1'b1;
                ram_addr    = len;
                len_next    = len + 1'b1;
                quotes_next = quotes ^ (item.data_byte == CH_QUOTE);
                res         = '{EV_ECHO, item.data_byte, LENGTH_W'(len + 1'b1),
                                quotes ^ (item.data_byte == CH_QUOTE)};
              end
            end
          end

          OP_READ: begin
            emit          = 1'b1;
            state_next    = ST_IDLE;
            res.event_res = EV_READ;
            res.out_byte  = in_range ? ram_rdata : 8'h00;
          end

          OP_RSVD: begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_SCAN: begin
        // One store read per cycle; data of the previous address is checked.
        if (scan_pend && (ram_rdata > CH_SPACE)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          res        = '{EV_SENT, 8'h00, LENGTH_W'(send_len), 1'b0};
        end else if ((scan_pend && (ram_rdata == CH_NUL)) || (scan_idx == send_len)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          res        = '{EV_BLANK, 8'h00, '0, 1'b0};
        end else begin
          mem_en         = 1'b1;
          ram_addr       = scan_idx;
          scan_idx_next  = scan_idx + 1'b1;
          scan_pend_next = 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers; a step whose result cannot leave yet is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      quotes    <= 1'b0;
      active    <= 1'b0;
      prev      <= CH_NUL;
      scan_pend <= 1'b0;
    end else if (!hold) begin
      state     <= state_next;
      len       <= len_next;
      quotes    <= quotes_next;
      active    <= active_next;
      prev      <= prev_next;
      scan_pend <= scan_pend_next;
    end
  end

  // Item and scan payload registers.
  always_ff @(posedge clk) begin
    if (!hold) begin
      item     <= item_next;
      scan_idx <= scan_idx_next;
      send_len <= send_len_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && can_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_emit) begin
      out_data <= res;
    end
  end

endmodule

// File: rtl/core/command_line_assembler.sv
// Command line assembler: collects terminal bytes into a line store held in a
// single-port synchronous RAM, with erase, quoting, session start and exit,
// and line send on a configurable terminator. Items are taken one at a time.
// A start, a read and most bytes pass ST_IDLE, which accepts the item and
// reads the store, and then ST_EXEC, which acts and loads the output
// register. A terminating byte adds a scan of the stored line, one store
// read per cycle, that stops at the first byte above space, the first NUL
// or the end of the line. The store port is the limit on that scan.
// Results wait in an output register; a full register stalls the step that
// would fill it. The store needs no clearing after reset. The termination
// mode register is written through the cfg channel and resets to CR.
// Depends on cla_pkg, cla_ctrl and cla_ram.
module command_line_assembler #(
  parameter int unsigned LINE_BYTES = cla_pkg::CLA_LINE_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  cla_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cla_pkg::out_item_t out_data
);
  import cla_pkg::*;

  localparam int unsigned AW = $clog2(LINE_BYTES);

  eol_mode_t     eol_mode;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Termination mode register; writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eol_mode <= TM_CR;
    end else if (cfg_valid) begin
      eol_mode <= eol_mode_t'(cfg_data);
    end
  end

  cla_ctrl #(
    .LINE_BYTES(LINE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .eol_mode  (eol_mode),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  cla_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule
